// ===== hw/rtl/text_terminal_escape_parser_core_defines.svh =====
// assertion macros shared by the checker
`ifndef TEXT_TERMINAL_ESCAPE_PARSER_CORE_DEFINES_SVH
`define TEXT_TERMINAL_ESCAPE_PARSER_CORE_DEFINES_SVH

// condition implies property in the same cycle
`define TTEP_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("assertion failed");

// condition implies property in the next cycle
`define TTEP_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ttep_pkg.sv =====
`timescale 1ns / 1ps
package ttep_pkg;

  localparam int unsigned PosBits = 8;
  localparam logic [PosBits-1:0] PosMax = '1;

  // byte codes
  localparam logic [7:0] ChEsc   = 8'd27;
  localparam logic [7:0] ChLbr   = 8'h5b;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChK     = 8'h4b;
  localparam logic [7:0] ChJ     = 8'h4a;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChBs    = 8'd8;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;

  // configuration register indexes
  localparam logic [2:0] RegCols   = 3'd0;
  localparam logic [2:0] RegRows   = 3'd1;
  localparam logic [2:0] RegNlRet  = 3'd2;
  localparam logic [2:0] RegCanon  = 3'd3;
  localparam logic [2:0] RegEcho   = 3'd4;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESC    = 3'b010,
    MODE_CSI    = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_RENDER = 2'd1,
    OP_FINAL  = 2'd2
  } op_kind_e;

  typedef enum logic [2:0] {
    CMD_CURSOR = 3'd0,
    CMD_SCROLL = 3'd1,
    CMD_DRAW   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SPAN   = 3'd4,
    CMD_ROWS   = 3'd5,
    CMD_DELETE = 3'd6
  } cmd_e;

  typedef struct packed {
    cmd_e         cmd;
    logic [7:0]   row;
    logic [8:0]   row_end;
    logic [7:0]   col_start;
    logic [8:0]   col_end;
    logic [7:0]   del_count;
    logic [7:0]   glyph_code;
    logic [7:0]   cursor_row;
    logic [7:0]   cursor_col;
    logic         last;
  } res_t;

  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
    logic       nl_ret;
    logic       canon;
    logic       echo;
  } cfg_t;

endpackage

// ===== hw/rtl/ttep_front.sv =====
`timescale 1ns / 1ps
module ttep_front #(
  parameter int unsigned ARG_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  logic [7:0]                byte_i,
  output logic                      op_push_o,
  output logic [2*ARG_BITS+9:0]     op_data_o
);
  import ttep_pkg::*;

  localparam int unsigned MulBits = ARG_BITS + 4;

  mode_e               mode_q, mode_d;
  logic [ARG_BITS-1:0] a0_q, a0_d, a1_q, a1_d;
  logic [3:0]          slot_q, slot_d;
  op_kind_e            kind;
  logic                is_digit;
  logic [3:0]          digit;
  logic [ARG_BITS-1:0] acc_arg, acc_sat;
  logic [MulBits-1:0]  acc_mul;

  // decimal accumulate with saturation
  always_comb begin
    acc_arg = (slot_q == 4'd0) ? a0_q : a1_q;
    digit   = 4'(byte_i - ChZero);
    acc_mul = {acc_arg, 3'b000} + MulBits'({acc_arg, 1'b0}) + MulBits'(digit);
    acc_sat = (acc_mul[MulBits-1:ARG_BITS] != 4'd0) ? '1 : acc_mul[ARG_BITS-1:0];
    is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  end

  // classify the byte and update the parse state
  always_comb begin
    mode_d = mode_q;
    a0_d   = a0_q;
    a1_d   = a1_q;
    slot_d = slot_q;
    kind   = OP_NOP;
    case (mode_q)
      MODE_ESC: begin
        if (byte_i == ChLbr) begin
          a0_d   = '0;
          a1_d   = '0;
          slot_d = 4'd0;
          mode_d = MODE_CSI;
        end else begin
          mode_d = MODE_NORMAL;
        end
      end
      MODE_CSI: begin
        if (is_digit) begin
          if (slot_q == 4'd0) a0_d = acc_sat;
          else if (slot_q == 4'd1) a1_d = acc_sat;
        end else if (byte_i == ChSemi) begin
          if (slot_q != 4'd15) slot_d = slot_q + 4'd1;
        end else begin
          kind   = OP_FINAL;
          mode_d = MODE_NORMAL;
        end
      end
      default: begin
        if (byte_i == ChEsc) mode_d = MODE_ESC;
        else begin
          mode_d = MODE_NORMAL;
          kind   = OP_RENDER;
        end
      end
    endcase
  end

  assign op_push_o = acc_i && (byte_i != 8'd0);
  assign op_data_o = {kind, byte_i, a0_d, a1_d};

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      a0_q   <= '0;
      a1_q   <= '0;
      slot_q <= 4'd0;
    end else if (op_push_o) begin
      mode_q <= mode_d;
      a0_q   <= a0_d;
      a1_q   <= a1_d;
      slot_q <= slot_d;
    end
  end

endmodule

// ===== hw/rtl/ttep_opq.sv =====
`timescale 1ns / 1ps
module ttep_opq #(
  parameter int unsigned W = 42
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  // two entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== hw/rtl/ttep_back.sv =====
`timescale 1ns / 1ps
module ttep_back #(
  parameter int unsigned ARG_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ttep_pkg::cfg_t        cfg_i,
  input  logic                  op_valid_i,
  input  logic [2*ARG_BITS+9:0] op_data_i,
  input  logic                  room_i,
  output logic                  fire_o,
  output logic                  two_o,
  output ttep_pkg::res_t        res0_o,
  output ttep_pkg::res_t        res1_o
);
  import ttep_pkg::*;

  logic [7:0]          row_q, row_d, col_q, col_d;
  op_kind_e            kind;
  logic [7:0]          ch;
  logic [ARG_BITS-1:0] a0, a1, a0m, a1m, adv, room_w;
  logic [ARG_BITS:0]   csum;
  logic [7:0]          room;
  res_t                r0, r1;
  logic                two;

  assign kind = op_kind_e'(op_data_i[2*ARG_BITS+9:2*ARG_BITS+8]);
  assign ch   = op_data_i[2*ARG_BITS+7:2*ARG_BITS];
  assign a0   = op_data_i[2*ARG_BITS-1:ARG_BITS];
  assign a1   = op_data_i[ARG_BITS-1:0];

  // argument helpers
  always_comb begin
    room   = (col_q < cfg_i.cols) ? cfg_i.cols - col_q : 8'd0;
    room_w = ARG_BITS'(room);
    adv    = (a0 == '0) ? ARG_BITS'(1) : a0;
    csum   = (ARG_BITS+1)'(col_q) + (ARG_BITS+1)'(adv);
    a0m    = (a0 == '0) ? a0 : a0 - ARG_BITS'(1);
    a1m    = (a1 == '0) ? a1 : a1 - ARG_BITS'(1);
  end

  // execute one operation
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    r0    = '0;
    r1    = '0;
    two   = 1'b0;
    r0.cmd = CMD_CURSOR;
    r1.cmd = CMD_CURSOR;
    case (kind)
      OP_RENDER: begin
        if (ch < 8'd8) begin
          r0.cmd = CMD_CURSOR;
        end else if (ch == ChLf) begin
          row_d = (row_q == PosMax) ? PosMax : row_q + 8'd1;
          if (cfg_i.nl_ret) col_d = 8'd0;
        end else if (ch == ChCr) begin
          col_d = 8'd0;
        end else if (ch == ChBs) begin
          if (col_q != 8'd0) begin
            col_d = col_q - 8'd1;
            if (cfg_i.canon && cfg_i.echo) begin
              r0.cmd       = CMD_CLEAR;
              r0.row       = row_q;
              r0.col_start = col_d;
              r0.col_end   = 9'(col_d) + 9'd1;
            end
          end
        end else begin
          // wrap, then scroll once, then draw
          if (col_q >= cfg_i.cols) begin
            col_d = 8'd0;
            row_d = (row_q == PosMax) ? PosMax : row_q + 8'd1;
          end
          if (row_d >= cfg_i.rows) begin
            two    = 1'b1;
            r0.cmd = CMD_SCROLL;
            if (row_d != 8'd0) row_d = row_d - 8'd1;
          end
          r1.cmd        = CMD_DRAW;
          r1.row        = row_d;
          r1.col_start  = col_d;
          r1.col_end    = 9'(col_d) + 9'd1;
          r1.glyph_code = ch;
          col_d = (col_d == PosMax) ? PosMax : col_d + 8'd1;
          if (!two) r0 = r1;
        end
      end
      OP_FINAL: begin
        case (ch)
          ChP: begin
            r0.cmd       = CMD_DELETE;
            r0.row       = row_q;
            r0.col_start = col_q;
            r0.col_end   = 9'(cfg_i.cols);
            r0.del_count = (a0 < room_w) ? a0[7:0] : room;
          end
          ChC: begin
            col_d = (csum < (ARG_BITS+1)'(cfg_i.cols)) ? csum[7:0] : cfg_i.cols;
          end
          ChK: begin
            if (a0 == ARG_BITS'(0)) begin
              r0.cmd = CMD_SPAN; r0.row = row_q;
              r0.col_start = col_q; r0.col_end = 9'(cfg_i.cols);
            end else if (a0 == ARG_BITS'(1)) begin
              r0.cmd = CMD_SPAN; r0.row = row_q;
              r0.col_end = 9'(col_q) + 9'd1;
            end else if (a0 == ARG_BITS'(2)) begin
              r0.cmd = CMD_SPAN; r0.row = row_q;
              r0.col_end = 9'(cfg_i.cols);
            end
          end
          ChJ: begin
            if (a0 == ARG_BITS'(0)) begin
              r0.cmd = CMD_ROWS; r0.row = row_q; r0.row_end = 9'(cfg_i.rows);
            end else if (a0 == ARG_BITS'(1)) begin
              r0.cmd = CMD_ROWS; r0.row_end = 9'(row_q) + 9'd1;
            end else if (a0 == ARG_BITS'(2) || a0 == ARG_BITS'(3)) begin
              r0.cmd = CMD_ROWS; r0.row_end = 9'(cfg_i.rows);
            end
          end
          ChH: begin
            row_d = (a0m < ARG_BITS'(cfg_i.rows)) ? a0m[7:0] : cfg_i.rows;
            col_d = (a1m < ARG_BITS'(cfg_i.cols)) ? a1m[7:0] : cfg_i.cols;
          end
          default: r0.cmd = CMD_CURSOR;
        endcase
      end
      default: r0.cmd = CMD_CURSOR;
    endcase
    r0.cursor_row = row_d;
    r0.cursor_col = col_d;
    r1.cursor_row = row_d;
    r1.cursor_col = col_d;
    r0.last       = !two;
    r1.last       = 1'b1;
  end

  assign fire_o = op_valid_i && room_i;
  assign two_o  = two;
  assign res0_o = r0;
  assign res1_o = r1;

  // cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 8'd0;
      col_q <= 8'd0;
    end else if (fire_o) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== hw/rtl/ttep_resq.sv =====
`timescale 1ns / 1ps
module ttep_resq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  logic           two_i,
  input  ttep_pkg::res_t w0_i,
  input  ttep_pkg::res_t w1_i,
  output logic           room_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ttep_pkg::res_t head_o
);
  import ttep_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       do_pop;

  assign room_o  = (cnt_q <= 3'd2);
  assign empty_o = (cnt_q == 3'd0);
  assign head_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  // storage, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= w0_i;
      if (two_i) mem_q[wptr_q + 2'd1] <= w1_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      if (wr_i)   wptr_q <= wptr_q + (two_i ? 2'd2 : 2'd1);
      if (do_pop) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + (wr_i ? (two_i ? 3'd2 : 3'd1) : 3'd0) - 3'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/text_terminal_escape_parser_core.sv =====
`timescale 1ns / 1ps
// path: a byte's first command can be popped once it has passed the op queue
//   and then the result queue, each a registered stage
// throughput: one byte per cycle while full is low; a byte with two commands
//   (scroll and draw) is drained by the single pop per cycle of the result queue
// reset: rst_ni low clears parse state, cursor, queues and the
//   configuration registers to their defaults
module text_terminal_escape_parser_core #(
  parameter int unsigned ARG_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] cmd_o,
  output logic [7:0] row_o,
  output logic [8:0] row_end_o,
  output logic [7:0] col_start_o,
  output logic [8:0] col_end_o,
  output logic [7:0] del_count_o,
  output logic [7:0] glyph_code_o,
  output logic [7:0] cursor_row_out_o,
  output logic [7:0] cursor_col_out_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import ttep_pkg::*;

  localparam int unsigned OpW = 2*ARG_BITS + 10;

  cfg_t           cfg_q;
  logic           acc, op_push, op_valid, fire, two, room;
  logic [OpW-1:0] op_in, op_out;
  res_t           r0, r1, head;

  assign acc         = push && !full;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols   <= 8'd113;
      cfg_q.rows   <= 8'd48;
      cfg_q.nl_ret <= 1'b0;
      cfg_q.canon  <= 1'b1;
      cfg_q.echo   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegCols:  cfg_q.cols   <= cfg_data_i;
        RegRows:  cfg_q.rows   <= cfg_data_i;
        RegNlRet: cfg_q.nl_ret <= cfg_data_i[0];
        RegCanon: cfg_q.canon  <= cfg_data_i[0];
        RegEcho:  cfg_q.echo   <= cfg_data_i[0];
        default:  cfg_q        <= cfg_q;
      endcase
    end
  end

  ttep_front #(.ARG_BITS(ARG_BITS)) u_front (
    .clk_i, .rst_ni, .acc_i(acc), .byte_i(in_byte_i),
    .op_push_o(op_push), .op_data_o(op_in)
  );

  ttep_opq #(.W(OpW)) u_opq (
    .clk_i, .rst_ni, .push_i(op_push), .data_i(op_in), .full_o(full),
    .pop_i(fire), .valid_o(op_valid), .data_o(op_out)
  );

  ttep_back #(.ARG_BITS(ARG_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .op_valid_i(op_valid), .op_data_i(op_out),
    .room_i(room), .fire_o(fire), .two_o(two), .res0_o(r0), .res1_o(r1)
  );

  ttep_resq u_resq (
    .clk_i, .rst_ni, .wr_i(fire), .two_i(two), .w0_i(r0), .w1_i(r1),
    .room_o(room), .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  assign cmd_o            = head.cmd;
  assign row_o            = head.row;
  assign row_end_o        = head.row_end;
  assign col_start_o      = head.col_start;
  assign col_end_o        = head.col_end;
  assign del_count_o      = head.del_count;
  assign glyph_code_o     = head.glyph_code;
  assign cursor_row_out_o = head.cursor_row;
  assign cursor_col_out_o = head.cursor_col;
  assign last_o           = head.last;

endmodule

// ===== hw/rtl/ttep_checker.sv =====
`timescale 1ns / 1ps
`include "text_terminal_escape_parser_core_defines.svh"
module ttep_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic [7:0] in_byte_i,
  input logic       empty,
  input logic       pop,
  input logic [2:0] cmd_o,
  input logic [7:0] row_o,
  input logic [8:0] row_end_o,
  input logic [7:0] col_start_o,
  input logic [8:0] col_end_o,
  input logic [7:0] del_count_o,
  input logic [7:0] glyph_code_o,
  input logic [7:0] cursor_row_out_o,
  input logic [7:0] cursor_col_out_o,
  input logic       last_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [2:0] cfg_index_i,
  input logic [7:0] cfg_data_i
);
  import ttep_pkg::*;

  // a scroll is always followed by its draw
  `TTEP_ASSERT_NOW(a_scroll_not_last, !empty && cmd_o == CMD_SCROLL, !last_o)
  // draw covers exactly one cell
  `TTEP_ASSERT_NOW(a_draw_one_cell, !empty && cmd_o == CMD_DRAW,
                   col_end_o == 9'(col_start_o) + 9'd1)
  // a waiting result holds until taken
  `TTEP_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(cmd_o) && $stable(last_o))
  // a popped scroll is followed by a draw at the head
  `TTEP_ASSERT_NEXT(a_scroll_draw, !empty && pop && cmd_o == CMD_SCROLL,
                    !empty && cmd_o == CMD_DRAW)

endmodule

bind text_terminal_escape_parser_core ttep_checker u_ttep_checker (.*);
